>>> rtl/rbop_pkg.sv
// Shared constants and types for the replay bind offset planner.
`timescale 1ns / 1ps

package rbop_pkg;

    localparam int ADDR_BITS_DEF  = 48;
    localparam int ALIGN_BITS_DEF = 25;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_CMP,
        S_CASE,
        S_GAP,
        S_RSET,
        S_ROUND,
        S_TOP,
        S_DONE
    } rbop_state_t;

    typedef enum logic {
        PH_QUOT,
        PH_REM
    } rbop_phase_t;

endpackage

>>> rtl/rbop_if.sv
// Valid/ready channel interfaces for the planner's item and result transactions.
`timescale 1ns / 1ps

interface rbop_item_if #(
    parameter int ADDR_BITS  = 48,
    parameter int ALIGN_BITS = 25
);
    logic                  valid;
    logic                  ready;
    logic                  first_in_group;
    logic [ADDR_BITS-1:0]  initial_alloc_size;
    logic [ADDR_BITS-1:0]  trace_offset;
    logic [ALIGN_BITS-1:0] trace_alignment;
    logic [ALIGN_BITS-1:0] replay_alignment;
    logic [ADDR_BITS-1:0]  trace_size;
    logic [ADDR_BITS-1:0]  replay_size;

    modport source (
        output valid, first_in_group, initial_alloc_size, trace_offset,
               trace_alignment, replay_alignment, trace_size, replay_size,
        input  ready
    );
    modport sink (
        input  valid, first_in_group, initial_alloc_size, trace_offset,
               trace_alignment, replay_alignment, trace_size, replay_size,
        output ready
    );
endinterface

interface rbop_result_if #(
    parameter int ADDR_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] replay_offset;
    logic [ADDR_BITS-1:0] alloc_size;
    logic                 overflow;

    modport source (
        output valid, replay_offset, alloc_size, overflow,
        input  ready
    );
    modport sink (
        input  valid, replay_offset, alloc_size, overflow,
        output ready
    );
endinterface

>>> rtl/replay_bind_offset_planner_unit.sv
// Top level of the replay bind offset planner: sequencer, shared divider/multiplier/adder.
`timescale 1ns / 1ps
//
// Usage:
//   item   : sink channel, one transaction per bound resource, sorted by trace
//            bind offset within a memory group; first_in_group restarts history.
//   result : source channel, one transaction per item with the aligned replay
//            offset, the running allocation size and a saturation flag.
// Sequencing:
//   One item at a time. The item passes through the shared restoring divider
//   for trace_offset / trace_alignment and then the shift-add multiplier (both
//   only when trace_alignment is nonzero), then through the divider again for
//   the round-up remainder (when replay_alignment is nonzero), plus up to eight
//   sequencer steps (accept, compare, case, gap, remainder setup, round-up,
//   top, done). item.ready is high only while the sequencer waits for work.
// Reset:
//   rst_n clears the sequencer, the output valid and the history, which then
//   acts as a zero-size resource at trace and replay offset zero.
// Stall:
//   The result register holds a finished transaction until result.ready; the
//   next item is accepted and worked meanwhile and waits only at its own end.

module replay_bind_offset_planner_unit #(
    parameter int ADDR_BITS  = rbop_pkg::ADDR_BITS_DEF,
    parameter int ALIGN_BITS = rbop_pkg::ALIGN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    rbop_item_if.sink           item,
    rbop_result_if.source       result
);
    import rbop_pkg::*;

    localparam int WW  = (ADDR_BITS > ALIGN_BITS) ? ADDR_BITS : ALIGN_BITS;
    localparam int PW  = ADDR_BITS + ALIGN_BITS;
    localparam int DCW = $clog2(ADDR_BITS + 1);
    localparam int MCW = $clog2(ALIGN_BITS + 1);

    rbop_state_t state_reg, state_next;
    rbop_phase_t phase_reg, phase_next;

    // latched item
    logic                  first_reg, first_next;
    logic [ADDR_BITS-1:0]  init_reg, init_next;
    logic [ADDR_BITS-1:0]  toff_reg, toff_next;
    logic [ALIGN_BITS-1:0] talign_reg, talign_next;
    logic [ALIGN_BITS-1:0] ralign_reg, ralign_next;
    logic [ADDR_BITS-1:0]  tsize_reg, tsize_next;
    logic [ADDR_BITS-1:0]  rsize_reg, rsize_next;

    // working values
    logic [ADDR_BITS-1:0]  off_reg, off_next;
    logic                  ovf_reg, ovf_next;
    logic [ADDR_BITS-1:0]  end_reg, end_next;
    logic [ADDR_BITS-1:0]  v_reg, v_next;

    // divider
    logic [ADDR_BITS-1:0]  dvd_reg, dvd_next;
    logic [ALIGN_BITS-1:0] rem_reg, rem_next;
    logic [DCW-1:0]        dcnt_reg, dcnt_next;

    // multiplier
    logic [PW-1:0]         acc_reg, acc_next;
    logic [PW-1:0]         mcand_reg, mcand_next;
    logic [ALIGN_BITS-1:0] mplr_reg, mplr_next;
    logic [MCW-1:0]        mcnt_reg, mcnt_next;

    // history
    logic [ADDR_BITS-1:0]  pto_reg, pto_next;
    logic [ADDR_BITS-1:0]  pts_reg, pts_next;
    logic [ADDR_BITS-1:0]  pro_reg, pro_next;
    logic [ADDR_BITS-1:0]  prs_reg, prs_next;
    logic [ADDR_BITS-1:0]  ralloc_reg, ralloc_next;

    // result register
    logic                  ovalid_reg, ovalid_next;
    logic [ADDR_BITS-1:0]  ooff_reg, ooff_next;
    logic [ADDR_BITS-1:0]  oalloc_reg, oalloc_next;
    logic                  oovf_reg, oovf_next;

    // shared divider step
    logic [ALIGN_BITS-1:0] dvs;
    logic [ALIGN_BITS:0]   dsh;
    logic [ALIGN_BITS:0]   ddiff;
    logic                  dbit;
    logic [ALIGN_BITS-1:0] drem;
    logic [ADDR_BITS-1:0]  dquot;

    // shared multiplier step
    logic [PW-1:0]         macc;

    // shared saturating adder
    logic [WW-1:0]         add_a, add_b;
    logic [WW:0]           add_sum;
    logic                  add_ovf;
    logic [ADDR_BITS-1:0]  add_res;

    logic                  accept;
    logic                  div_last, mul_last;
    logic                  out_free;

    assign accept   = item.valid && item.ready;
    assign div_last = (dcnt_reg == DCW'(1));
    assign mul_last = (mcnt_reg == MCW'(1));
    assign out_free = !ovalid_reg || result.ready;

    assign item.ready           = (state_reg == S_IDLE);
    assign result.valid         = ovalid_reg;
    assign result.replay_offset = ooff_reg;
    assign result.alloc_size    = oalloc_reg;
    assign result.overflow      = oovf_reg;

    // restoring divide, one quotient bit a cycle
    assign dvs   = (phase_reg == PH_QUOT) ? talign_reg : ralign_reg;
    assign dsh   = {rem_reg, dvd_reg[ADDR_BITS-1]};
    assign ddiff = dsh - {1'b0, dvs};
    assign dbit  = !ddiff[ALIGN_BITS];
    assign drem  = dbit ? ddiff[ALIGN_BITS-1:0] : dsh[ALIGN_BITS-1:0];
    assign dquot = {dvd_reg[ADDR_BITS-2:0], dbit};

    // shift-add multiply, one multiplier bit a cycle
    assign macc = mplr_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    // operand select for the saturating adder
    always_comb
    begin
        add_a = WW'(off_reg);
        add_b = WW'(rsize_reg);
        case (state_reg)
            S_CMP:
            begin
                add_a = WW'(pto_reg);
                add_b = WW'(pts_reg);
            end
            S_CASE:
            begin
                if (toff_reg > end_reg)
                begin
                    add_a = WW'(pro_reg);
                    add_b = WW'(prs_reg);
                end
                else
                begin
                    add_a = WW'(pro_reg);
                    add_b = WW'(toff_reg - pto_reg);
                end
            end
            S_GAP:
            begin
                add_a = WW'(v_reg);
                add_b = WW'(toff_reg - end_reg);
            end
            S_ROUND:
            begin
                add_a = WW'(off_reg);
                add_b = WW'(ralign_reg - rem_reg);
            end
            default:
            begin
                add_a = WW'(off_reg);
                add_b = WW'(rsize_reg);
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign add_ovf = |add_sum[WW:ADDR_BITS];
    assign add_res = add_ovf ? {ADDR_BITS{1'b1}} : add_sum[ADDR_BITS-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = (item.trace_alignment != '0) ? S_DIV : S_CMP;
            S_DIV:
                if (div_last)
                    state_next = (phase_reg == PH_QUOT) ? S_MUL : S_ROUND;
            S_MUL:
                if (mul_last)
                    state_next = S_CMP;
            S_CMP:
                if (first_reg || toff_reg == pto_reg || pts_reg == '0)
                    state_next = S_RSET;
                else
                    state_next = S_CASE;
            S_CASE:
                state_next = (toff_reg > end_reg) ? S_GAP : S_RSET;
            S_GAP:
                state_next = S_RSET;
            S_RSET:
                state_next = (ralign_reg != '0) ? S_DIV : S_TOP;
            S_ROUND:
                state_next = S_TOP;
            S_TOP:
                state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        init_next   = init_reg;
        toff_next   = toff_reg;
        talign_next = talign_reg;
        ralign_next = ralign_reg;
        tsize_next  = tsize_reg;
        rsize_next  = rsize_reg;
        off_next    = off_reg;
        ovf_next    = ovf_reg;
        end_next    = end_reg;
        v_next      = v_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplr_next   = mplr_reg;
        mcnt_next   = mcnt_reg;
        pto_next    = pto_reg;
        pts_next    = pts_reg;
        pro_next    = pro_reg;
        prs_next    = prs_reg;
        ralloc_next = ralloc_reg;
        ooff_next   = ooff_reg;
        oalloc_next = oalloc_reg;
        oovf_next   = oovf_reg;
        ovalid_next = ovalid_reg && !result.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    first_next  = item.first_in_group;
                    init_next   = item.initial_alloc_size;
                    toff_next   = item.trace_offset;
                    talign_next = item.trace_alignment;
                    ralign_next = item.replay_alignment;
                    tsize_next  = item.trace_size;
                    rsize_next  = item.replay_size;
                    off_next    = item.trace_offset;
                    ovf_next    = 1'b0;
                    phase_next  = PH_QUOT;
                    dvd_next    = item.trace_offset;
                    rem_next    = '0;
                    dcnt_next   = DCW'(ADDR_BITS);
                end
            end
            S_DIV:
            begin
                dvd_next  = dquot;
                rem_next  = drem;
                dcnt_next = dcnt_reg - DCW'(1);
                if (div_last && phase_reg == PH_QUOT)
                begin
                    acc_next   = '0;
                    mcand_next = PW'(dquot);
                    mplr_next  = ralign_reg;
                    mcnt_next  = MCW'(ALIGN_BITS);
                end
            end
            S_MUL:
            begin
                acc_next   = macc;
                mcand_next = mcand_reg << 1;
                mplr_next  = mplr_reg >> 1;
                mcnt_next  = mcnt_reg - MCW'(1);
                if (mul_last)
                begin
                    if (|macc[PW-1:ADDR_BITS])
                    begin
                        off_next = {ADDR_BITS{1'b1}};
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        off_next = macc[ADDR_BITS-1:0];
                    end
                end
            end
            S_CMP:
            begin
                if (!first_reg)
                begin
                    if (toff_reg == pto_reg)
                    begin
                        off_next = pro_reg;
                    end
                    else if (pts_reg != '0)
                    begin
                        // trace end of the previous resource
                        end_next = add_res;
                        ovf_next = ovf_reg | add_ovf;
                    end
                end
            end
            S_CASE:
            begin
                if (toff_reg > end_reg)
                begin
                    v_next   = add_res;
                    ovf_next = ovf_reg | add_ovf;
                end
                else if (toff_reg > pto_reg && toff_reg < end_reg)
                begin
                    off_next = add_res;
                    ovf_next = ovf_reg | add_ovf;
                end
            end
            S_GAP:
            begin
                off_next = add_res;
                ovf_next = ovf_reg | add_ovf;
            end
            S_RSET:
            begin
                phase_next = PH_REM;
                dvd_next   = off_reg;
                rem_next   = '0;
                dcnt_next  = DCW'(ADDR_BITS);
            end
            S_ROUND:
            begin
                if (rem_reg != '0)
                begin
                    off_next = add_res;
                    ovf_next = ovf_reg | add_ovf;
                end
            end
            S_TOP:
            begin
                ovf_next = ovf_reg | add_ovf;
                if (first_reg)
                    ralloc_next = (add_res > init_reg) ? add_res : init_reg;
                else
                    ralloc_next = (add_res > ralloc_reg) ? add_res : ralloc_reg;
                pto_next = toff_reg;
                pts_next = tsize_reg;
                pro_next = off_reg;
                prs_next = rsize_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ooff_next   = off_reg;
                    oalloc_next = ralloc_reg;
                    oovf_next   = ovf_reg;
                end
            end
            default:
            begin
                ovalid_next = ovalid_reg && !result.ready;
            end
        endcase
    end

    // control and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_QUOT;
            dcnt_reg   <= '0;
            mcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            pto_reg    <= '0;
            pts_reg    <= '0;
            pro_reg    <= '0;
            prs_reg    <= '0;
            ralloc_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            dcnt_reg   <= dcnt_next;
            mcnt_reg   <= mcnt_next;
            ovalid_reg <= ovalid_next;
            pto_reg    <= pto_next;
            pts_reg    <= pts_next;
            pro_reg    <= pro_next;
            prs_reg    <= prs_next;
            ralloc_reg <= ralloc_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        init_reg   <= init_next;
        toff_reg   <= toff_next;
        talign_reg <= talign_next;
        ralign_reg <= ralign_next;
        tsize_reg  <= tsize_next;
        rsize_reg  <= rsize_next;
        off_reg    <= off_next;
        ovf_reg    <= ovf_next;
        end_reg    <= end_next;
        v_reg      <= v_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplr_reg   <= mplr_next;
        ooff_reg   <= ooff_next;
        oalloc_reg <= oalloc_next;
        oovf_reg   <= oovf_next;
    end

endmodule

>>> rtl/rbop_checker.sv
// Port-level checker for the planner, bound to the top level.
`timescale 1ns / 1ps

module rbop_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_overflow
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_overflow))
        else $error("overflow changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a transaction while busy");

    // a result never appears the cycle after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind replay_bind_offset_planner_unit rbop_checker u_rbop_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_overflow (result.overflow)
);

>>> dv/tb_top.sv
// Self-checking bench for the replay bind offset planner: directed and random items.
`timescale 1ns / 1ps

module tb_top;
    import rbop_pkg::*;

    localparam int AW = ADDR_BITS_DEF;
    localparam int LW = ALIGN_BITS_DEF;
    localparam logic [AW-1:0] AMAX = {AW{1'b1}};
    localparam logic [LW-1:0] LMAX_ALIGN = 25'd16777216;

    typedef struct packed {
        logic          first_in_group;
        logic [AW-1:0] initial_alloc_size;
        logic [AW-1:0] trace_offset;
        logic [LW-1:0] trace_alignment;
        logic [LW-1:0] replay_alignment;
        logic [AW-1:0] trace_size;
        logic [AW-1:0] replay_size;
    } bind_item_t;

    typedef struct packed {
        logic [AW-1:0] replay_offset;
        logic [AW-1:0] alloc_size;
        logic          overflow;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rbop_item_if   #(.ADDR_BITS(AW), .ALIGN_BITS(LW)) item_ch ();
    rbop_result_if #(.ADDR_BITS(AW))                  res_ch ();

    replay_bind_offset_planner_unit #(.ADDR_BITS(AW), .ALIGN_BITS(LW)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch.sink),
        .result(res_ch.source)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor history: the resource placed just before, plus the group's running size.
    logic [AW-1:0] hist_toff = '0;
    logic [AW-1:0] hist_tsize = '0;
    logic [AW-1:0] hist_roff = '0;
    logic [AW-1:0] hist_rsize = '0;
    logic [AW-1:0] hist_alloc = '0;

    bind_item_t pending_items[$];
    placement_t expected_placements[$];
    int  mismatches = 0;
    int  placed = 0;
    int  ovf_seen = 0;
    bit  hold_sender = 1'b0;
    bit  pressure_done = 1'b0;
    bit  item_taken = 1'b0;

    // Saturating add in the block's width; flag on clamp.
    function automatic logic [AW-1:0] add_clamp(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                                inout bit ovf);
        logic [AW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s[AW])
            begin
                ovf = 1'b1;
                return AMAX;
            end
            return s[AW-1:0];
        end
    endfunction

    // Work out one placement and advance the history, as the block does per transaction.
    function automatic placement_t place_resource(input bind_item_t it);
        placement_t    p;
        bit            ovf;
        logic [AW-1:0] off, quo, fin_end, v, rem;
        logic [2*AW-1:0] prod;
        begin
            ovf = 1'b0;
            off = it.trace_offset;
            if (it.trace_alignment != 0)
            begin
                quo  = it.trace_offset / AW'(it.trace_alignment);
                prod = (2*AW)'(it.replay_alignment) * (2*AW)'(quo);
                if (prod > (2*AW)'(AMAX))
                begin
                    ovf = 1'b1;
                    off = AMAX;
                end
                else
                    off = prod[AW-1:0];
            end
            if (!it.first_in_group)
            begin
                if (it.trace_offset == hist_toff)
                    off = hist_roff;
                else if (hist_tsize != 0)
                begin
                    fin_end = add_clamp(hist_toff, hist_tsize, ovf);
                    if (it.trace_offset > fin_end)
                    begin
                        v   = add_clamp(hist_roff, hist_rsize, ovf);
                        off = add_clamp(v, it.trace_offset - fin_end, ovf);
                    end
                    else if (it.trace_offset > hist_toff && it.trace_offset < fin_end)
                        off = add_clamp(hist_roff, it.trace_offset - hist_toff, ovf);
                end
            end
            if (it.replay_alignment != 0)
            begin
                rem = off % AW'(it.replay_alignment);
                if (rem != 0)
                    off = add_clamp(off, AW'(it.replay_alignment) - rem, ovf);
            end
            v = add_clamp(off, it.replay_size, ovf);
            if (it.first_in_group)
                hist_alloc = (v > it.initial_alloc_size) ? v : it.initial_alloc_size;
            else
                hist_alloc = (v > hist_alloc) ? v : hist_alloc;
            hist_toff  = it.trace_offset;
            hist_tsize = it.trace_size;
            hist_roff  = off;
            hist_rsize = it.replay_size;
            p.replay_offset = off;
            p.alloc_size    = hist_alloc;
            p.overflow      = ovf;
            return p;
        end
    endfunction

    // Driver: bursts with random gaps; hold valid until accepted.
    int burst_left = 0;
    int gap_left = 0;
    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.first_in_group = 1'b0;
        item_ch.initial_alloc_size = '0;
        item_ch.trace_offset = '0;
        item_ch.trace_alignment = '0;
        item_ch.replay_alignment = '0;
        item_ch.trace_size = '0;
        item_ch.replay_size = '0;
        res_ch.ready = 1'b0;
    end

    // Record whether the driven transaction was taken at the last rising edge.
    always @(posedge clk)
    begin
        item_taken <= rst_n && item_ch.valid && item_ch.ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
                void'(pending_items.pop_front());
            if (!item_ch.valid || item_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0 && !hold_sender)
                begin
                    item_ch.valid <= 1'b1;
                    {item_ch.first_in_group, item_ch.initial_alloc_size, item_ch.trace_offset,
                     item_ch.trace_alignment, item_ch.replay_alignment, item_ch.trace_size,
                     item_ch.replay_size} <= pending_items[0];
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(12, 0);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(150, 0);
                    end
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: long ready stretches mixed with stalls of varying length.
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(9, 0) == 0)
                    stall_left <= $urandom_range(($urandom_range(1, 0) == 1) ? 300 : 20, 1);
            end
        end
    end

    // Monitor: predict on item acceptance, check on result acceptance.
    always @(posedge clk)
    begin
        placement_t got, want;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                expected_placements.push_back(place_resource({item_ch.first_in_group,
                    item_ch.initial_alloc_size, item_ch.trace_offset, item_ch.trace_alignment,
                    item_ch.replay_alignment, item_ch.trace_size, item_ch.replay_size}));
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.replay_offset, res_ch.alloc_size, res_ch.overflow};
                placed++;
                if (got.overflow)
                    ovf_seen++;
                if (expected_placements.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: off=%h alloc=%h ovf=%b",
                                 got.replay_offset, got.alloc_size, got.overflow);
                end
                else
                begin
                    want = expected_placements.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch #%0d: off exp %h got %h, ",
                                      "alloc exp %h got %h, ovf exp %b got %b"},
                                     placed, want.replay_offset, got.replay_offset,
                                     want.alloc_size, got.alloc_size,
                                     want.overflow, got.overflow);
                    end
                end
            end
        end
    end

    function automatic logic [LW-1:0] rand_align();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return LW'(1) << $urandom_range(24, 0);
            2: return LMAX_ALIGN;
            3: return LW'($urandom_range(16777216, 1));
            default: return LW'(1) << $urandom_range(8, 0);
        endcase
    endfunction

    function automatic logic [AW-1:0] rand_addr();
        case ($urandom_range(4, 0))
            0: return AW'({$urandom, $urandom});
            1: return AMAX - AW'($urandom_range(4096, 0));
            2: return '0;
            default: return AW'($urandom_range(1 << 20, 0));
        endcase
    endfunction

    task automatic queue_item(input bit f, input logic [AW-1:0] ia, input logic [AW-1:0] to,
                              input logic [LW-1:0] ta, input logic [LW-1:0] ra,
                              input logic [AW-1:0] ts, input logic [AW-1:0] rs);
        bind_item_t it;
        begin
            it = '{f, ia, to, ta, ra, ts, rs};
            pending_items.push_back(it);
        end
    endtask

    // A well-formed group: sorted offsets, with equal, gap, overlap and adjacent steps.
    task automatic queue_group();
        int            n;
        logic [AW-1:0] to, ts;
        logic [LW-1:0] ta, ra;
        begin
            n  = $urandom_range(6, 1);
            to = ($urandom_range(7, 0) == 0) ? rand_addr() : AW'($urandom_range(1 << 16, 0));
            ta = rand_align();
            ra = rand_align();
            for (int k = 0; k < n; k++)
            begin
                ts = ($urandom_range(5, 0) == 0) ? '0 : AW'($urandom_range(1 << 14, 1));
                queue_item(k == 0, rand_addr(), to, ta,
                           ($urandom_range(3, 0) == 0) ? rand_align() : ra,
                           ts, ($urandom_range(5, 0) == 0) ? rand_addr()
                                                          : AW'($urandom_range(1 << 14, 0)));
                case ($urandom_range(3, 0))
                    0: ;
                    1: to = to + ts + AW'($urandom_range(4096, 1));
                    2: to = to + AW'($urandom_range(32, 1));
                    default: to = to + ts;
                endcase
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_items.size() != 0 || item_ch.valid || expected_placements.size() != 0)
                @(posedge clk);
            repeat (150) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: history from reset without a first mark, extremes, each relation case.
        queue_item(0, '0, AW'(100), '0, '0, AW'(10), AW'(5));
        queue_item(0, AMAX, AMAX, LW'(1), LMAX_ALIGN, AMAX, AMAX);
        queue_item(1, AMAX, '0, LMAX_ALIGN, LMAX_ALIGN, AW'(64), AW'(64));
        queue_item(0, '0, '0, LMAX_ALIGN, LMAX_ALIGN, AW'(64), AW'(32));
        queue_item(0, '0, AW'(32), '0, '0, AW'(64), AW'(32));
        queue_item(0, '0, AW'(200), '0, LW'(16), AW'(8), AW'(8));
        queue_item(0, '0, AW'(208), '0, '0, AW'(8), AW'(8));
        queue_item(0, '0, AW'(100), '0, '0, AW'(8), AW'(8));
        queue_item(1, AW'(4096), AW'(4096), LW'(256), LW'(512), AW'(256), AW'(512));
        queue_item(0, '0, AW'(4352), LW'(256), LW'(512), AW'(256), AW'(512));
        queue_item(1, '0, AMAX - AW'(10), '0, '0, AW'(100), AW'(1));
        queue_item(0, '0, AMAX, '0, LW'(3), AW'(1), AW'(1));
        queue_item(1, '0, AW'(7), LW'(3), LMAX_ALIGN - LW'(1), AW'(5), AMAX);
        queue_item(1, AMAX, AMAX - AW'(1), LW'(1), LW'(1), AMAX, '0);
        queue_item(0, '0, AMAX, LW'(7), LW'(5), AMAX, AMAX);
        wait_drained();

        // Random: mostly sorted groups, some noise items.
        while (pending_items.size() + placed < 1650)
        begin
            if ($urandom_range(9, 0) == 0)
                queue_item($urandom_range(1, 0), rand_addr(), rand_addr(), rand_align(),
                           rand_align(), rand_addr(), rand_addr());
            else
                queue_group();
            if (pending_items.size() > 40)
                while (pending_items.size() > 4)
                    @(posedge clk);
            if (placed > 800 && !pressure_done)
            begin
                // Hold the sender until the block has caught up completely.
                pressure_done = 1'b1;
                hold_sender = 1'b1;
                while (item_ch.valid || expected_placements.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
        end
        wait_drained();

        $display("covered %0d placements, %0d of them saturated,", placed, ovf_seen);
        $display("across directed cases and random sorted and unsorted groups");
        if (mismatches == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> sim.f
rtl/rbop_pkg.sv
rtl/rbop_if.sv
rtl/replay_bind_offset_planner_unit.sv
rtl/rbop_checker.sv
dv/tb_top.sv
